### hw/rtl/ifdyu_pkg.sv
package ifdyu_pkg;

	// packet layout
	localparam int unsigned PACKET_LEN = 11;
	localparam int unsigned OFF_W      = 4;

	localparam logic [OFF_W-1:0] OFF_HEADER = 4'd0;
	localparam logic [OFF_W-1:0] OFF_TYPE   = 4'd1;
	localparam logic [OFF_W-1:0] OFF_X_LO   = 4'd2;
	localparam logic [OFF_W-1:0] OFF_X_HI   = 4'd3;
	localparam logic [OFF_W-1:0] OFF_Y_LO   = 4'd4;
	localparam logic [OFF_W-1:0] OFF_Y_HI   = 4'd5;
	localparam logic [OFF_W-1:0] OFF_Z_LO   = 4'd6;
	localparam logic [OFF_W-1:0] OFF_Z_HI   = 4'd7;
	localparam logic [OFF_W-1:0] OFF_LAST   = 4'(PACKET_LEN - 1);

	// field widths
	localparam int unsigned AXIS_W  = 27;
	localparam int unsigned YAW_W   = 40;
	localparam int unsigned TDATA_W = 96;

	// scale factors, Q15 result from a raw 16-bit reading
	localparam logic signed [YAW_W-1:0] RATE_SCALE  = 40'sd2000;
	localparam logic signed [YAW_W-1:0] ANGLE_SCALE = 40'sd180;
	// one turn is 360 * 2^15 = 45 * 2^18
	localparam logic signed [YAW_W-1:0] TURN_MULT   = 40'sd45;
	localparam int unsigned             TURN_SHIFT  = 18;
	// raw jump threshold: diff*180 > 300*2^15  <=>  diff > 54613
	localparam logic signed [16:0]      JUMP_RAW    = 17'sd54613;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_HEADER     = 2'd0,
		REG_RATE_TYPE  = 2'd1,
		REG_ANGLE_TYPE = 2'd2
	} cfg_reg_t;

	localparam logic [7:0] HEADER_RESET     = 8'd85;
	localparam logic [7:0] RATE_TYPE_RESET  = 8'd82;
	localparam logic [7:0] ANGLE_TYPE_RESET = 8'd83;

	// result kind codes
	localparam logic KIND_RATE  = 1'b0;
	localparam logic KIND_ANGLE = 1'b1;

endpackage

### hw/rtl/imu_frame_decode_yaw_unwrap.sv
// IMU serial frame decoder with yaw unwrapping.
// Slave stream: one received byte per transfer, s_tdata[7:0] = data_byte,
// s_tuser[0] = action (1 clears the yaw turn counter), s_tuser[1] = frame_start.
// Master stream: one transfer per rate or angle packet, raised by the packet's
// eighth data byte; m_tuser = result kind (0 rate, 1 angle), m_tdata holds the
// three Q15 axes (pitch, roll, yaw).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 header byte,
// 1 rate type byte, 2 angle type byte); write only while the block is idle.
// The input register takes the byte, then decode, unwrap and scaling fill the
// result register that drives m_tvalid. Throughput is one byte per cycle while
// no result waits on m_tready, set by the single pass from input register to
// result register; the yaw unwrap and turn offset add are the longest path.
// Reset clears the frame state (waiting for a frame start), the turn counter,
// the previous yaw and both valid flags, and restores register defaults.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more byte if empty, then s_tready drops until m_tready.
module imu_frame_decode_yaw_unwrap
	import ifdyu_pkg::*;
#(
	parameter int unsigned PACKETS_PER_FRAME = 3,
	parameter int unsigned TURN_COUNT_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic [1:0]         s_tuser,   // [0] action, [1] frame_start

	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [26:0] first_axis, [53:27] second_axis,
	                                      // [93:54] third_axis, [95:94] zero
	output logic [0:0]         m_tuser,   // [0] result_kind

	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int unsigned PKT_W = $clog2(PACKETS_PER_FRAME + 1);
	localparam logic [PKT_W-1:0] PKT_END = PKT_W'(PACKETS_PER_FRAME);
	localparam int unsigned TCB = TURN_COUNT_BITS;
	localparam logic signed [TCB-1:0] TURN_MAX = {1'b0, {(TCB-1){1'b1}}};
	localparam logic signed [TCB-1:0] TURN_MIN = {1'b1, {(TCB-2){1'b0}}, 1'b1};
	// raw 16-bit reading times a scale of at most 2000 fits in 28 signed bits
	localparam int unsigned PROD_W  = 28;
	localparam int unsigned SCALE_W = 12;
	localparam int unsigned TM_W    = TCB + 6;

	// configuration registers
	logic [7:0] header_q, rate_type_q, angle_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= HEADER_RESET;
			rate_type_q  <= RATE_TYPE_RESET;
			angle_type_q <= ANGLE_TYPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER:     header_q     <= cfg_data;
				REG_RATE_TYPE:  rate_type_q  <= cfg_data;
				REG_ANGLE_TYPE: angle_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       action_s1, start_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_valid_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser[0];
			start_s1  <= s_tuser[1];
			byte_s1   <= s_tdata;
		end
	end

	// frame state
	logic [OFF_W-1:0]     offset_q;
	logic [PKT_W-1:0]     packet_q;
	logic                 dropped_q;
	logic [7:0]           type_q;
	logic [7:0]           low_q;
	logic [15:0]          word0_q, word1_q;
	logic signed [TCB-1:0] turn_q;
	logic signed [15:0]   prev_yaw_q;

	logic [OFF_W-1:0]     offset_cur;
	logic [PKT_W-1:0]     packet_cur;
	logic                 dropped_cur;
	logic                 live;
	logic                 is_rate, is_angle, emit;
	logic signed [15:0]   r0, r1, r2;
	logic signed [16:0]   jump;
	logic signed [TCB-1:0] turn_next;
	logic signed [TM_W-1:0] turn_mul;
	logic signed [YAW_W-1:0] turn_term;
	logic signed [SCALE_W-1:0] scale;
	logic signed [PROD_W-1:0] prod0, prod1, prod2;
	logic                 take;

	assign take        = valid_s1 && advance;
	assign offset_cur  = start_s1 ? '0 : offset_q;
	assign packet_cur  = start_s1 ? '0 : packet_q;
	assign dropped_cur = start_s1 ? 1'b0 : dropped_q;
	assign live        = !action_s1 && !dropped_cur && (packet_cur != PKT_END);

	assign r0 = signed'(word0_q);
	assign r1 = signed'(word1_q);
	assign r2 = signed'({byte_s1, low_q});

	assign is_rate  = (type_q == rate_type_q);
	assign is_angle = !is_rate && (type_q == angle_type_q);
	assign emit     = live && (offset_cur == OFF_Z_HI) && (is_rate || is_angle);

	// yaw unwrap on raw values, saturating turn counter
	assign jump = 17'(r2) - 17'(prev_yaw_q);

	always_comb begin
		turn_next = turn_q;
		if (jump > JUMP_RAW && turn_q > TURN_MIN)
			turn_next = turn_q - 1'b1;
		if (jump < -JUMP_RAW && turn_q < TURN_MAX)
			turn_next = turn_q + 1'b1;
	end

	assign turn_mul  = TM_W'(turn_next) * TM_W'(TURN_MULT);
	assign turn_term = YAW_W'(turn_mul) <<< TURN_SHIFT;

	assign scale = is_rate ? SCALE_W'(RATE_SCALE) : SCALE_W'(ANGLE_SCALE);
	assign prod0 = PROD_W'(r0) * PROD_W'(scale);
	assign prod1 = PROD_W'(r1) * PROD_W'(scale);
	assign prod2 = PROD_W'(r2) * PROD_W'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			packet_q   <= '0;
			dropped_q  <= 1'b1;
			turn_q     <= '0;
			prev_yaw_q <= '0;
		end else if (take) begin
			if (action_s1) begin
				turn_q <= '0;
			end else begin
				offset_q  <= offset_cur;
				packet_q  <= packet_cur;
				dropped_q <= dropped_cur;
				if (live) begin
					if (offset_cur == OFF_LAST) begin
						offset_q <= '0;
						packet_q <= packet_cur + 1'b1;
					end else begin
						offset_q <= offset_cur + 1'b1;
					end
					if (offset_cur == OFF_HEADER && byte_s1 != header_q)
						dropped_q <= 1'b1;
					if (emit && is_angle) begin
						turn_q     <= turn_next;
						prev_yaw_q <= r2;
					end
				end
			end
		end
	end

	// packet payload holding registers
	always_ff @(posedge clk) begin
		if (take && live) begin
			case (offset_cur) inside
				OFF_TYPE: type_q <= byte_s1;
				OFF_X_LO, OFF_Y_LO, OFF_Z_LO: low_q <= byte_s1;
				OFF_X_HI: word0_q <= {byte_s1, low_q};
				OFF_Y_HI: word1_q <= {byte_s1, low_q};
				default: ;
			endcase
		end
	end

	// result register
	logic                    kind_q;
	logic signed [AXIS_W-1:0] first_q, second_q;
	logic signed [YAW_W-1:0]  third_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q   <= is_rate ? KIND_RATE : KIND_ANGLE;
			first_q  <= prod0[AXIS_W-1:0];
			second_q <= prod1[AXIS_W-1:0];
			third_q  <= is_rate ? YAW_W'(prod2) : YAW_W'(prod2) + turn_term;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {2'b00, third_q, second_q, first_q};

endmodule
